// ===== hw/rtl/kwm_pkg.sv =====
// Package with the entry layout, commands and status codes of the merge queue.
`default_nettype none
package kwm_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned SourceW = 3;
  localparam int unsigned EntryW = ValueW + SourceW;
  localparam int unsigned FillW = 4;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_FULL       = 2'd2,
    ST_RESERVED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_OUT
  } state_e;

  typedef logic [EntryW-1:0] entry_t;

  function automatic entry_t pack_entry(logic signed [ValueW-1:0] v, logic [SourceW-1:0] s);
    pack_entry = {~v[ValueW-1], v[ValueW-2:0], s};
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kwm_if.sv =====
// Interfaces for the command and result channels of the merge queue.
`default_nettype none
interface kwm_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [31:0]       in_value;
  logic [2:0]               in_source;
  modport source (output valid, command, in_value, in_source, input ready);
  modport sink (input valid, command, in_value, in_source, output ready);
endinterface

interface kwm_res_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       out_value;
  logic [2:0]               out_source;
  logic [1:0]               status;
  logic [3:0]               fill_count;
  modport source (output valid, out_value, out_source, status, fill_count, input ready);
  modport sink (input valid, out_value, out_source, status, fill_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/k_way_merge_priority_queue.sv =====
// Top level of the merge queue: entry memory, minimum scan and result register.
//
// Channel  Dir  Transfer when         Payload
// cmd_i    in   valid && ready        command, in_value, in_source
// res_o    out  valid && ready        out_value, out_source, status, fill_count
//
// An insert or a rejected command passes through the S_OUT state on its way to the result register.
// A pop reads the memory one entry per cycle through the single read port, then passes through S_MOVE and S_OUT.
// Reset clears the count and control state; the entry memory is not cleared.
// A new command is taken only once the previous result has been transferred.
`default_nettype none
module k_way_merge_priority_queue
  import kwm_pkg::*;
#(
  parameter int unsigned WAYS = 8
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  kwm_cmd_if.sink   cmd_i,
  kwm_res_if.source res_o
);
  localparam int unsigned AddrW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CntW = $clog2(WAYS + 1);

  entry_t mem_q [WAYS];
  entry_t rdata_q;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] best_q, best_d;
  entry_t best_val_q, best_val_d;
  logic rd_en;
  logic [AddrW-1:0] rd_addr;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t wr_data;
  logic res_valid_q, res_valid_d;
  logic signed [31:0] res_value_q, res_value_d;
  logic [2:0] res_source_q, res_source_d;
  logic [1:0] res_status_q, res_status_d;
  logic [3:0] res_fill_q, res_fill_d;
  logic [CntW-1:0] last;
  logic take;

  assign take = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && !res_valid_q;
  assign last = count_q - CntW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    best_q <= best_d;
    best_val_q <= best_val_d;
    res_value_q <= res_value_d;
    res_source_q <= res_source_d;
    res_status_q <= res_status_d;
    res_fill_q <= res_fill_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    best_d = best_q;
    best_val_d = best_val_q;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = count_q[AddrW-1:0];
    wr_data = pack_entry(cmd_i.in_value, cmd_i.in_source);
    res_valid_d = res_valid_q && !res_o.ready;
    res_value_d = res_value_q;
    res_source_d = res_source_q;
    res_status_d = res_status_q;
    res_fill_d = res_fill_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          res_value_d = '0;
          res_source_d = '0;
          res_status_d = ST_OK;
          if (cmd_i.command == CMD_INSERT) begin
            if (count_q >= CntW'(WAYS)) begin
              res_status_d = ST_FULL;
            end else begin
              wr_en = 1'b1;
              count_d = count_q + CntW'(1);
            end
            state_d = S_OUT;
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d = S_OUT;
          end else begin
            rd_en = 1'b1;
            rd_addr = '0;
            idx_d = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == '0 || rdata_q < best_val_q) begin
          best_val_d = rdata_q;
          best_d = idx_q[AddrW-1:0];
        end
        idx_d = idx_q + CntW'(1);
        rd_en = 1'b1;
        if (idx_q == last) begin
          rd_addr = last[AddrW-1:0];
          state_d = S_MOVE;
        end else begin
          rd_addr = idx_d[AddrW-1:0];
        end
      end
      S_MOVE: begin
        wr_en = 1'b1;
        wr_addr = best_q;
        wr_data = rdata_q;
        count_d = last;
        res_value_d = {~best_val_q[EntryW-1], best_val_q[EntryW-2:SourceW]};
        res_source_d = best_val_q[SourceW-1:0];
        res_status_d = ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_d = 1'b1;
        res_fill_d = 4'(count_q);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.valid = res_valid_q;
  assign res_o.out_value = res_value_q;
  assign res_o.out_source = res_source_q;
  assign res_o.status = res_status_q;
  assign res_o.fill_count = res_fill_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(WAYS)) else $error("count exceeds depth");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_i.ready) else $error("ready while busy");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not shrink count");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> res_o.valid) else $error("result lost");
`endif
endmodule
`default_nettype wire
